// File: src/i2cmts_pkg.sv
package i2cmts_pkg;

    localparam int unsigned MAX_READ = 32;

    localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd10;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_W_START = 4'd1;
    localparam logic [3:0] PH_W_SLA   = 4'd2;
    localparam logic [3:0] PH_W_DATA  = 4'd3;
    localparam logic [3:0] PH_R_START = 4'd4;
    localparam logic [3:0] PH_R_SLA   = 4'd5;
    localparam logic [3:0] PH_R_DATA  = 4'd6;

    // Request types.
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_STATUS  = 2'd2;
    localparam logic [1:0] REQ_TIMEOUT = 2'd3;

    // Bus commands.
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_TX      = 3'd2;
    localparam logic [2:0] CMD_RX_ACK  = 3'd3;
    localparam logic [2:0] CMD_RX_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;

    // TWI status codes.
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NACK    = 8'h58;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] dev_addr;
        logic [7:0] write_data;
        logic [5:0] read_len;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic       failed;
        logic [5:0] byte_count;
    } t_result;

    typedef struct packed {
        logic [3:0] phase;
        logic       is_read;
        logic [6:0] target;
        logic [7:0] out_byte;
        logic [3:0] attempts;
        logic [5:0] remaining;
        logic [5:0] received;
    } t_state;

endpackage

// File: src/i2cmts_if.sv
interface i2cmts_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] write_data;
    logic [5:0] read_len;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;

    modport source (output valid, req_type, dev_addr, write_data, read_len, bus_status,
                    rx_byte, input ready);
    modport sink (input valid, req_type, dev_addr, write_data, read_len, bus_status,
                  rx_byte, output ready);
endinterface

interface i2cmts_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       done_res;
    logic       failed;
    logic [5:0] byte_count;

    modport source (output valid, cmd, tx_byte, rx_valid, rx_data, done_res, failed,
                    byte_count, input ready);
    modport sink (input valid, cmd, tx_byte, rx_valid, rx_data, done_res, failed,
                  byte_count, output ready);
endinterface

interface i2cmts_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: src/i2c_master_transaction_sequencer_unit.sv
// I2C master transaction sequencer.
// i_req carries write and read requests, bus status events and timeout
// events. Each accepted transaction yields exactly one result on o_res: the
// next bus command, the byte to transmit, any received byte, and the
// done/failed flags that close a transaction.
// i_cfg writes the address attempt limit; it is always ready and should be
// written only while no transaction is in flight.
// A request is captured by the input register when accepted, and its result
// is loaded into the result register once that register is free. Throughput is
// one transaction per cycle while o_res is not stalled; the phase update
// is a single level of decode between the input register and the result register.
// When o_res is stalled the result holds and the input register fills;
// i_req.ready drops only when both are occupied.
// Synchronous reset (i_rst_n low) returns the sequencer to idle, clears
// both pipeline stages and sets the attempt limit to ten.
module i2c_master_transaction_sequencer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cmts_in_if.sink    i_req,
    i2cmts_cfg_if.sink   i_cfg,
    i2cmts_out_if.source o_res
);
    import i2cmts_pkg::*;

    logic       r_in_valid;
    t_item      r_item;
    logic       r_out_valid;
    t_result    r_res;
    t_state     r_state;
    logic [3:0] r_max_attempts;

    t_state     n_state;
    t_result    n_res;
    t_item      in_item;
    logic       adv;

    assign in_item = '{req_type:   i_req.req_type,
                       dev_addr:   i_req.dev_addr,
                       write_data: i_req.write_data,
                       read_len:   i_req.read_len,
                       bus_status: i_req.bus_status,
                       rx_byte:    i_req.rx_byte};

    assign adv         = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;

    i2cmts_step u_step (
        .i_state        (r_state),
        .i_item         (r_item),
        .i_max_attempts (r_max_attempts),
        .o_state        (n_state),
        .o_result       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state        <= '0;
            r_max_attempts <= MAX_ATTEMPTS_RESET;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (adv && r_in_valid) begin
                r_state <= n_state;
            end
            if (i_cfg.valid) begin
                r_max_attempts <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= in_item;
        end
        if (adv && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.cmd        = r_res.cmd;
    assign o_res.tx_byte    = r_res.tx_byte;
    assign o_res.rx_valid   = r_res.rx_valid;
    assign o_res.rx_data    = r_res.rx_data;
    assign o_res.done_res   = r_res.done_res;
    assign o_res.failed     = r_res.failed;
    assign o_res.byte_count = r_res.byte_count;

    // A finishing result always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && n_res.done_res) |=> (r_state.phase == PH_IDLE))
        else $error("transaction finished but sequencer not idle");

    a_fail_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_res.failed) |-> o_res.done_res)
        else $error("failure flagged without done");

    a_rx_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_res.rx_valid) |->
        (o_res.cmd == CMD_STOP || o_res.cmd == CMD_RX_ACK || o_res.cmd == CMD_RX_NACK))
        else $error("received byte with unexpected command");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.received <= 6'(MAX_READ)) && (r_state.remaining <= 6'(MAX_READ)))
        else $error("read counters beyond maximum read length");

endmodule

// File: src/i2cmts_step.sv
module i2cmts_step (
    input  i2cmts_pkg::t_state  i_state,
    input  i2cmts_pkg::t_item   i_item,
    input  logic [3:0]          i_max_attempts,
    output i2cmts_pkg::t_state  o_state,
    output i2cmts_pkg::t_result o_result
);
    import i2cmts_pkg::*;

    localparam logic [5:0] MAX_READ_W = 6'(MAX_READ);

    t_state     n_st;
    t_result    res;
    logic [5:0] rem_next;
    logic [5:0] rlen_sat;

    always_comb begin
        n_st     = i_state;
        res      = '0;
        rem_next = '0;
        rlen_sat = (i_item.read_len > MAX_READ_W) ? MAX_READ_W : i_item.read_len;

        if (i_state.phase == PH_IDLE) begin
            if (i_item.req_type == REQ_WRITE) begin
                n_st.is_read   = 1'b0;
                n_st.target    = i_item.dev_addr;
                n_st.out_byte  = i_item.write_data;
                n_st.received  = '0;
                n_st.remaining = '0;
                n_st.attempts  = '0;
                if (i_max_attempts == 4'd0) begin
                    res.cmd      = CMD_STOP;
                    res.done_res = 1'b1;
                    res.failed   = 1'b1;
                end else begin
                    n_st.attempts = 4'd1;
                    res.cmd       = CMD_START;
                    n_st.phase    = PH_W_START;
                end
            end else if (i_item.req_type == REQ_READ) begin
                n_st.is_read   = 1'b1;
                n_st.target    = i_item.dev_addr;
                n_st.out_byte  = '0;
                n_st.received  = '0;
                n_st.remaining = rlen_sat;
                res.cmd        = CMD_START;
                n_st.phase     = PH_R_START;
            end
        end else if (i_item.req_type == REQ_TIMEOUT) begin
            res.cmd      = CMD_STOP;
            res.done_res = 1'b1;
            res.failed   = 1'b1;
            n_st.phase   = PH_IDLE;
        end else if (i_item.req_type == REQ_STATUS) begin
            case (i_state.phase)
                PH_W_START, PH_R_START: begin
                    if (i_item.bus_status inside {ST_START, ST_RSTART}) begin
                        res.cmd     = CMD_TX;
                        res.tx_byte = {i_state.target, i_state.is_read};
                        n_st.phase  = (i_state.phase == PH_W_START) ? PH_W_SLA : PH_R_SLA;
                    end else if (i_item.bus_status == ST_ARB_LOST) begin
                        res.cmd = CMD_START;
                    end else begin
                        // A failed start leaves the bus alone: no stop is sent.
                        res.done_res = 1'b1;
                        res.failed   = 1'b1;
                        n_st.phase   = PH_IDLE;
                    end
                end
                PH_W_SLA: begin
                    if (i_item.bus_status == ST_SLAW_ACK) begin
                        res.cmd     = CMD_TX;
                        res.tx_byte = i_state.out_byte;
                        n_st.phase  = PH_W_DATA;
                    end else if (i_item.bus_status == ST_SLAW_NACK) begin
                        if (i_state.attempts >= i_max_attempts) begin
                            res.cmd      = CMD_STOP;
                            res.done_res = 1'b1;
                            res.failed   = 1'b1;
                            n_st.phase   = PH_IDLE;
                        end else begin
                            n_st.attempts = i_state.attempts + 4'd1;
                            res.cmd       = CMD_START;
                            n_st.phase    = PH_W_START;
                        end
                    end else if (i_item.bus_status == ST_ARB_LOST) begin
                        res.cmd    = CMD_START;
                        n_st.phase = PH_W_START;
                    end else begin
                        res.cmd      = CMD_STOP;
                        res.done_res = 1'b1;
                        res.failed   = 1'b1;
                        n_st.phase   = PH_IDLE;
                    end
                end
                PH_W_DATA: begin
                    if (i_item.bus_status inside {ST_DATA_ACK, ST_DATA_NACK}) begin
                        res.cmd      = CMD_STOP;
                        res.done_res = 1'b1;
                        n_st.phase   = PH_IDLE;
                    end else if (i_item.bus_status == ST_ARB_LOST) begin
                        res.cmd    = CMD_START;
                        n_st.phase = PH_W_START;
                    end else begin
                        res.cmd      = CMD_STOP;
                        res.done_res = 1'b1;
                        res.failed   = 1'b1;
                        n_st.phase   = PH_IDLE;
                    end
                end
                PH_R_SLA: begin
                    if (i_item.bus_status == ST_SLAR_ACK) begin
                        if (i_state.remaining != '0) begin
                            res.cmd    = (i_state.remaining > 6'd1) ? CMD_RX_ACK : CMD_RX_NACK;
                            n_st.phase = PH_R_DATA;
                        end else begin
                            res.cmd      = CMD_STOP;
                            res.done_res = 1'b1;
                            n_st.phase   = PH_IDLE;
                        end
                    end else if (i_item.bus_status == ST_SLAR_NACK) begin
                        res.cmd      = CMD_STOP;
                        res.done_res = 1'b1;
                        n_st.phase   = PH_IDLE;
                    end else if (i_item.bus_status == ST_ARB_LOST) begin
                        res.cmd    = CMD_START;
                        n_st.phase = PH_R_START;
                    end else begin
                        res.cmd      = CMD_STOP;
                        res.done_res = 1'b1;
                        res.failed   = 1'b1;
                        n_st.phase   = PH_IDLE;
                    end
                end
                PH_R_DATA: begin
                    if (i_item.bus_status inside {ST_RX_ACK, ST_RX_NACK}) begin
                        res.rx_valid = 1'b1;
                        res.rx_data  = i_item.rx_byte;
                        n_st.received = i_state.received + 6'd1;
                        // A NACKed byte ends the read even if more were expected.
                        rem_next = (i_item.bus_status == ST_RX_NACK || i_state.remaining == '0)
                                   ? 6'd0 : i_state.remaining - 6'd1;
                        n_st.remaining = rem_next;
                        if (rem_next != '0) begin
                            res.cmd    = (rem_next > 6'd1) ? CMD_RX_ACK : CMD_RX_NACK;
                            n_st.phase = PH_R_DATA;
                        end else begin
                            res.cmd      = CMD_STOP;
                            res.done_res = 1'b1;
                            n_st.phase   = PH_IDLE;
                        end
                    end else begin
                        res.cmd      = CMD_STOP;
                        res.done_res = 1'b1;
                        res.failed   = 1'b1;
                        n_st.phase   = PH_IDLE;
                    end
                end
                default: begin
                    n_st.phase = PH_IDLE;
                end
            endcase
        end

        res.byte_count = n_st.received;
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

// File: test/i2c_master_transaction_sequencer_unit_test.sv
module i2c_master_transaction_sequencer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cmts_pkg::*;

    localparam int CYCLE_LIMIT = 250000;

    typedef struct packed {
        t_state  st;
        t_result res;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cmts_in_if  req_if ();
    i2cmts_cfg_if cfg_if ();
    i2cmts_out_if res_if ();

    i2c_master_transaction_sequencer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #5ns i_clk = ~i_clk;

    // Sequencer state mirrored on the checking side, updated at acceptance.
    t_state     bus_state;
    logic [3:0] bus_attempt_limit;
    // Separate copy used while building stimulus, so that it can follow the phase.
    t_state     plan_state;
    logic [3:0] plan_attempt_limit;

    t_item   pending_q[$];
    t_result expected_q[$];

    int mismatches = 0;
    int items_queued = 0;
    int items_accepted = 0;
    int working_items = 0;
    int results_seen = 0;
    int ok_done = 0;
    int failed_done = 0;
    int bytes_delivered = 0;
    int cycle_count = 0;

    logic  req_taken = 1'b0;
    t_item drv_item;
    int    burst_left = 0;
    int    gap_left = 0;
    logic  hold_for_drain = 1'b0;
    logic  first_gap = 1'b1;

    int stall_mode = 0;
    int stall_period = 2;
    int stall_epoch_left = 0;
    int stall_tick = 0;

    function automatic t_result close_out(logic [2:0] cmd, logic fail);
        t_result r;
        r = '0;
        r.cmd = cmd;
        r.done_res = 1'b1;
        r.failed = fail;
        return r;
    endfunction

    // One step of the sequencer: next state and the result of one transaction.
    function automatic t_step sequence_step(t_state s, logic [3:0] limit, t_item it);
        t_step r;
        r.st = s;
        r.res = '0;
        if (s.phase == PH_IDLE) begin
            if (it.req_type == REQ_WRITE) begin
                r.st.is_read = 1'b0;
                r.st.target = it.dev_addr;
                r.st.out_byte = it.write_data;
                r.st.received = '0;
                r.st.remaining = '0;
                r.st.attempts = '0;
                if (limit == 4'd0) begin
                    r.res = close_out(CMD_STOP, 1'b1);
                end else begin
                    r.st.attempts = 4'd1;
                    r.res.cmd = CMD_START;
                    r.st.phase = PH_W_START;
                end
            end else if (it.req_type == REQ_READ) begin
                r.st.is_read = 1'b1;
                r.st.target = it.dev_addr;
                r.st.out_byte = '0;
                r.st.received = '0;
                r.st.remaining = (it.read_len > MAX_READ) ? 6'(MAX_READ) : it.read_len;
                r.res.cmd = CMD_START;
                r.st.phase = PH_R_START;
            end
        end else if (it.req_type == REQ_TIMEOUT) begin
            r.res = close_out(CMD_STOP, 1'b1);
            r.st.phase = PH_IDLE;
        end else if (it.req_type == REQ_STATUS) begin
            case (s.phase)
                PH_W_START, PH_R_START: begin
                    if (it.bus_status == ST_START || it.bus_status == ST_RSTART) begin
                        r.res.cmd = CMD_TX;
                        r.res.tx_byte = {s.target, s.is_read};
                        r.st.phase = (s.phase == PH_W_START) ? PH_W_SLA : PH_R_SLA;
                    end else if (it.bus_status == ST_ARB_LOST) begin
                        r.res.cmd = CMD_START;
                    end else begin
                        // A failed start leaves nothing to stop on the bus.
                        r.res = close_out(CMD_NONE, 1'b1);
                        r.st.phase = PH_IDLE;
                    end
                end
                PH_W_SLA: begin
                    if (it.bus_status == ST_SLAW_ACK) begin
                        r.res.cmd = CMD_TX;
                        r.res.tx_byte = s.out_byte;
                        r.st.phase = PH_W_DATA;
                    end else if (it.bus_status == ST_SLAW_NACK) begin
                        if (s.attempts >= limit) begin
                            r.res = close_out(CMD_STOP, 1'b1);
                            r.st.phase = PH_IDLE;
                        end else begin
                            r.st.attempts = s.attempts + 4'd1;
                            r.res.cmd = CMD_START;
                            r.st.phase = PH_W_START;
                        end
                    end else if (it.bus_status == ST_ARB_LOST) begin
                        r.res.cmd = CMD_START;
                        r.st.phase = PH_W_START;
                    end else begin
                        r.res = close_out(CMD_STOP, 1'b1);
                        r.st.phase = PH_IDLE;
                    end
                end
                PH_W_DATA: begin
                    if (it.bus_status == ST_DATA_ACK || it.bus_status == ST_DATA_NACK) begin
                        r.res = close_out(CMD_STOP, 1'b0);
                        r.st.phase = PH_IDLE;
                    end else if (it.bus_status == ST_ARB_LOST) begin
                        r.res.cmd = CMD_START;
                        r.st.phase = PH_W_START;
                    end else begin
                        r.res = close_out(CMD_STOP, 1'b1);
                        r.st.phase = PH_IDLE;
                    end
                end
                PH_R_SLA: begin
                    if (it.bus_status == ST_SLAR_ACK) begin
                        if (s.remaining != 0) begin
                            r.res.cmd = (s.remaining > 1) ? CMD_RX_ACK : CMD_RX_NACK;
                            r.st.phase = PH_R_DATA;
                        end else begin
                            r.res = close_out(CMD_STOP, 1'b0);
                            r.st.phase = PH_IDLE;
                        end
                    end else if (it.bus_status == ST_SLAR_NACK) begin
                        r.res = close_out(CMD_STOP, 1'b0);
                        r.st.phase = PH_IDLE;
                    end else if (it.bus_status == ST_ARB_LOST) begin
                        r.res.cmd = CMD_START;
                        r.st.phase = PH_R_START;
                    end else begin
                        r.res = close_out(CMD_STOP, 1'b1);
                        r.st.phase = PH_IDLE;
                    end
                end
                PH_R_DATA: begin
                    if (it.bus_status == ST_RX_ACK || it.bus_status == ST_RX_NACK) begin
                        r.st.received = s.received + 6'd1;
                        // A NACKed byte ends the read even if more were asked for.
                        r.st.remaining = (it.bus_status == ST_RX_NACK || s.remaining == 0) ?
                                         6'd0 : s.remaining - 6'd1;
                        if (r.st.remaining != 0) begin
                            r.res.cmd = (r.st.remaining > 1) ? CMD_RX_ACK : CMD_RX_NACK;
                        end else begin
                            r.res = close_out(CMD_STOP, 1'b0);
                            r.st.phase = PH_IDLE;
                        end
                        r.res.rx_valid = 1'b1;
                        r.res.rx_data = it.rx_byte;
                    end else begin
                        r.res = close_out(CMD_STOP, 1'b1);
                        r.st.phase = PH_IDLE;
                    end
                end
                default: begin
                    r.st.phase = PH_IDLE;
                end
            endcase
        end
        r.res.byte_count = r.st.received;
        return r;
    endfunction

    task automatic queue_item(t_item it);
        t_step nxt;
        nxt = sequence_step(plan_state, plan_attempt_limit, it);
        plan_state = nxt.st;
        pending_q.push_back(it);
        items_queued++;
        if (nxt.res.cmd != CMD_NONE || nxt.res.done_res) begin
            working_items++;
        end
    endtask

    function automatic t_item make_item(logic [1:0] req, logic [6:0] addr, logic [7:0] data,
                                        logic [5:0] len, logic [7:0] status, logic [7:0] rxb);
        t_item it;
        it.req_type = req;
        it.dev_addr = addr;
        it.write_data = data;
        it.read_len = len;
        it.bus_status = status;
        it.rx_byte = rxb;
        return it;
    endfunction

    // Mostly the status a healthy bus would return for the current phase, with
    // some timeouts, stray requests and arbitrary status codes mixed in.
    function automatic t_item next_bus_item(logic nack_heavy);
        t_item it;
        int    n;
        int    m;
        it.req_type = 2'($urandom_range(0, 3));
        it.dev_addr = 7'($urandom_range(0, 127));
        it.write_data = 8'($urandom_range(0, 255));
        it.read_len = ($urandom_range(0, 99) < 12) ? 6'($urandom_range(0, 63)) :
                                                     6'($urandom_range(0, 5));
        it.bus_status = 8'($urandom_range(0, 255));
        it.rx_byte = 8'($urandom_range(0, 255));
        n = $urandom_range(0, 99);
        m = $urandom_range(0, 99);
        if (plan_state.phase == PH_IDLE) begin
            if (n < 3) it.req_type = REQ_STATUS;
            else if (n < 5) it.req_type = REQ_TIMEOUT;
            else if (n < 52) it.req_type = REQ_WRITE;
            else it.req_type = REQ_READ;
        end else if (n < 2) begin
            it.req_type = REQ_TIMEOUT;
        end else if (n < 4) begin
            it.req_type = ($urandom_range(0, 1) == 0) ? REQ_WRITE : REQ_READ;
        end else begin
            it.req_type = REQ_STATUS;
            if (n >= 7) begin
                case (plan_state.phase)
                    PH_W_START, PH_R_START: begin
                        if (m < 85) it.bus_status = (m < 60) ? ST_START : ST_RSTART;
                        else it.bus_status = ST_ARB_LOST;
                    end
                    PH_W_SLA: begin
                        if (nack_heavy) begin
                            it.bus_status = (m < 85) ? ST_SLAW_NACK : ST_SLAW_ACK;
                        end else begin
                            if (m < 65) it.bus_status = ST_SLAW_ACK;
                            else if (m < 90) it.bus_status = ST_SLAW_NACK;
                            else it.bus_status = ST_ARB_LOST;
                        end
                    end
                    PH_W_DATA: begin
                        if (m < 45) it.bus_status = ST_DATA_ACK;
                        else if (m < 85) it.bus_status = ST_DATA_NACK;
                        else it.bus_status = ST_ARB_LOST;
                    end
                    PH_R_SLA: begin
                        if (m < 75) it.bus_status = ST_SLAR_ACK;
                        else if (m < 90) it.bus_status = ST_SLAR_NACK;
                        else it.bus_status = ST_ARB_LOST;
                    end
                    PH_R_DATA: begin
                        if (plan_state.remaining == 1)
                            it.bus_status = (m < 85) ? ST_RX_NACK : ST_RX_ACK;
                        else
                            it.bus_status = (m < 92) ? ST_RX_ACK : ST_RX_NACK;
                    end
                    default: begin
                    end
                endcase
            end
        end
        return it;
    endfunction

    task automatic plan_bus_traffic(int count, logic nack_heavy);
        int goal;
        goal = working_items + count;
        while (working_items < goal) begin
            queue_item(next_bus_item(nack_heavy));
        end
        // Leave the sequencer idle at the end of each stretch.
        if (plan_state.phase != PH_IDLE) begin
            queue_item(make_item(REQ_TIMEOUT, 7'h00, 8'h00, 6'd0, 8'h00, 8'h00));
        end
    endtask

    task automatic wait_until_quiet();
        while (items_accepted != items_queued || expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_attempt_limit(logic [3:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        plan_attempt_limit = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch on result %0d, expected 0x%0h, got 0x%0h",
                     $time, field, results_seen, want, got);
            mismatches++;
        end
    endtask

    // Request driver: bursts of transactions separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_taken) begin
            // Hold the current transaction until it is taken.
        end else if (gap_left > 0) begin
            req_if.valid <= 1'b0;
            gap_left--;
        end else if (hold_for_drain && expected_q.size() != 0) begin
            req_if.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
            drv_item = pending_q.pop_front();
            hold_for_drain = 1'b0;
            req_if.valid <= 1'b1;
            req_if.req_type <= drv_item.req_type;
            req_if.dev_addr <= drv_item.dev_addr;
            req_if.write_data <= drv_item.write_data;
            req_if.read_len <= drv_item.read_len;
            req_if.bus_status <= drv_item.bus_status;
            req_if.rx_byte <= drv_item.rx_byte;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                hold_for_drain = first_gap || ($urandom_range(0, 9) == 0);
                first_gap = 1'b0;
            end else begin
                burst_left--;
            end
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Result sink: ready follows one of four randomly chosen patterns, switched at the end of each random epoch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (stall_epoch_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_period = $urandom_range(2, 9);
                stall_epoch_left = $urandom_range(30, 200);
            end else begin
                stall_epoch_left--;
            end
            stall_tick++;
            case (stall_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= (stall_tick % stall_period) != 0;
                2: res_if.ready <= (stall_tick % stall_period) == 0;
                default: res_if.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Monitor: predicts on every accepted request and checks every result.
    always @(posedge i_clk) begin
        t_item   seen;
        t_result got;
        t_result want;
        t_step   nxt;
        if (!i_rst_n) begin
            bus_state = '0;
            bus_attempt_limit = MAX_ATTEMPTS_RESET;
            req_taken = 1'b0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                bus_attempt_limit = cfg_if.data;
            end
            if (res_if.valid && res_if.ready) begin
                got.cmd = res_if.cmd;
                got.tx_byte = res_if.tx_byte;
                got.rx_valid = res_if.rx_valid;
                got.rx_data = res_if.rx_data;
                got.done_res = res_if.done_res;
                got.failed = res_if.failed;
                got.byte_count = res_if.byte_count;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got %p", $time, got);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("cmd", want.cmd, got.cmd);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("rx_valid", want.rx_valid, got.rx_valid);
                    check_field("rx_data", want.rx_data, got.rx_data);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("failed", want.failed, got.failed);
                    check_field("byte_count", want.byte_count, got.byte_count);
                    if (want.done_res && want.failed) failed_done++;
                    else if (want.done_res) ok_done++;
                    if (want.rx_valid) bytes_delivered++;
                end
                results_seen++;
            end
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                seen.req_type = req_if.req_type;
                seen.dev_addr = req_if.dev_addr;
                seen.write_data = req_if.write_data;
                seen.read_len = req_if.read_len;
                seen.bus_status = req_if.bus_status;
                seen.rx_byte = req_if.rx_byte;
                nxt = sequence_step(bus_state, bus_attempt_limit, seen);
                bus_state = nxt.st;
                expected_q.push_back(nxt.res);
                items_accepted++;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("FAIL i2c_master_transaction_sequencer_unit");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_WRITE;
        req_if.dev_addr = '0;
        req_if.write_data = '0;
        req_if.read_len = '0;
        req_if.bus_status = '0;
        req_if.rx_byte = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
        plan_state = '0;
        plan_attempt_limit = MAX_ATTEMPTS_RESET;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Events while idle, then a write with address retry, a lost
        // arbitration during data and a data NACK that still succeeds.
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_START, 8'h00));
        queue_item(make_item(REQ_TIMEOUT, 7'h7F, 8'hFF, 6'd63, 8'hFF, 8'hFF));
        queue_item(make_item(REQ_WRITE, 7'h7F, 8'hFF, 6'd0, 8'h00, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_RSTART, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_SLAW_NACK, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_START, 8'h00));
        queue_item(make_item(REQ_READ, 7'h15, 8'h00, 6'd4, 8'h00, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_SLAW_ACK, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_ARB_LOST, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_START, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_SLAW_ACK, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_DATA_NACK, 8'h00));
        // Two-byte read with the last byte NACKed, then a zero-length read.
        queue_item(make_item(REQ_READ, 7'h00, 8'h00, 6'd2, 8'h00, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_START, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_SLAR_ACK, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_RX_ACK, 8'hA5));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_RX_NACK, 8'h00));
        queue_item(make_item(REQ_READ, 7'h2A, 8'h00, 6'd0, 8'h00, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_START, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_SLAR_ACK, 8'h00));
        // A bad start status, then an oversized read refused by the slave.
        queue_item(make_item(REQ_WRITE, 7'h00, 8'h00, 6'd0, 8'h00, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, 8'h00, 8'h00));
        queue_item(make_item(REQ_READ, 7'h01, 8'h00, 6'd63, 8'h00, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_START, 8'h00));
        queue_item(make_item(REQ_STATUS, 7'h00, 8'h00, 6'd0, ST_SLAR_NACK, 8'h00));
        plan_bus_traffic(280, 1'b0);
        wait_until_quiet();

        // With no attempts allowed every write fails at once.
        write_attempt_limit(4'd0);
        plan_bus_traffic(80, 1'b0);
        wait_until_quiet();

        write_attempt_limit(4'd1);
        plan_bus_traffic(250, 1'b0);
        wait_until_quiet();

        // Mostly address NACKs so that the full retry budget gets used up.
        write_attempt_limit(4'd15);
        plan_bus_traffic(250, 1'b1);
        wait_until_quiet();

        write_attempt_limit(4'($urandom_range(2, 14)));
        plan_bus_traffic(300, 1'b0);
        wait_until_quiet();
        repeat (10) @(negedge i_clk);

        $display("Checked %0d results from %0d transactions under five attempt limits.",
                 results_seen, items_accepted);
        $display("%0d transfers succeeded, %0d failed, %0d bytes were received.",
                 ok_done, failed_done, bytes_delivered);
        if (mismatches == 0) begin
            $display("PASS i2c_master_transaction_sequencer_unit");
        end else begin
            $display("FAIL i2c_master_transaction_sequencer_unit");
        end
        $finish;
    end

endmodule

// File: i2c_master_transaction_sequencer_unit.f
src/i2cmts_pkg.sv
src/i2cmts_if.sv
src/i2cmts_step.sv
src/i2c_master_transaction_sequencer_unit.sv
test/i2c_master_transaction_sequencer_unit_test.sv
